>>> rtl/core/brg_pkg.sv
// Package with shared constants and types of the bounded random generator.
`timescale 1ns / 1ps
package brg_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [DataW-1:0] SeedValue = 32'd12345;
  localparam logic [DataW-1:0] MaskOne   = 32'hFFFF_FFFE;
  localparam logic [DataW-1:0] MaskTwo   = 32'hFFFF_FFF8;
  localparam logic [DataW-1:0] MaskThree = 32'hFFFF_FFF0;
  localparam logic [DataW-1:0] MaskFour  = 32'hFFFF_FF80;

  typedef struct packed {
    logic [DataW-1:0] raw;
    logic [DataW-1:0] limit;
  } brg_job_t;

  typedef struct packed {
    logic     valid;
    brg_job_t job;
  } brg_push_t;

  typedef struct packed {
    logic     empty;
    brg_job_t job;
  } brg_head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } brg_state_e;

endpackage

>>> rtl/core/brg_if.sv
// Handshake interfaces for the request and response channels.
`timescale 1ns / 1ps
interface brg_req_if;
  logic                     valid;
  logic                     ready;
  logic [brg_pkg::DataW-1:0] limit;

  modport source (output valid, output limit, input ready);
  modport sink (input valid, input limit, output ready);
endinterface

interface brg_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [brg_pkg::DataW-1:0] value;
  logic                     limit_zero;

  modport source (output valid, output value, output limit_zero, input ready);
  modport sink (input valid, input value, input limit_zero, output ready);
endinterface

>>> rtl/core/brg_front.sv
// Front end: accepts requests, advances the Tausworthe components and queues the job.
`timescale 1ns / 1ps
module brg_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  brg_req_if.sink            req_i,
  input  logic               full_i,
  output brg_pkg::brg_push_t push_o
);
  import brg_pkg::*;

  logic [DataW-1:0] comp_one_q, comp_one_d;
  logic [DataW-1:0] comp_two_q, comp_two_d;
  logic [DataW-1:0] comp_three_q, comp_three_d;
  logic [DataW-1:0] comp_four_q, comp_four_d;
  logic             accept;

  assign req_i.ready = !full_i;
  assign accept      = req_i.valid && !full_i;

  always_comb begin
    comp_one_d   = ((comp_one_q & MaskOne) << 18)
                 ^ (((comp_one_q << 6) ^ comp_one_q) >> 13);
    comp_two_d   = ((comp_two_q & MaskTwo) << 2)
                 ^ (((comp_two_q << 2) ^ comp_two_q) >> 27);
    comp_three_d = ((comp_three_q & MaskThree) << 7)
                 ^ (((comp_three_q << 13) ^ comp_three_q) >> 21);
    comp_four_d  = ((comp_four_q & MaskFour) << 13)
                 ^ (((comp_four_q << 3) ^ comp_four_q) >> 12);
  end

  assign push_o.valid     = accept;
  assign push_o.job.raw   = comp_one_d ^ comp_two_d ^ comp_three_d ^ comp_four_d;
  assign push_o.job.limit = req_i.limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_one_q   <= SeedValue;
      comp_two_q   <= SeedValue;
      comp_three_q <= SeedValue;
      comp_four_q  <= SeedValue;
    end else if (accept) begin
      comp_one_q   <= comp_one_d;
      comp_two_q   <= comp_two_d;
      comp_three_q <= comp_three_d;
      comp_four_q  <= comp_four_d;
    end
  end

endmodule

>>> rtl/core/brg_fifo.sv
// Short job queue between the front end and the divider back end.
`timescale 1ns / 1ps
module brg_fifo #(
  parameter int unsigned Depth = brg_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  brg_pkg::brg_push_t push_i,
  output logic               full_o,
  input  logic               pop_i,
  output brg_pkg::brg_head_t head_o
);
  import brg_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  brg_job_t          entry_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o       = (count_q == FullCnt);
  assign head_o.empty = (count_q == '0);
  assign head_o.job   = entry_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && !head_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.job;
    end
  end

endmodule

>>> rtl/core/brg_back.sv
// Back end: radix-2 restoring divider for the remainder and the response register.
`timescale 1ns / 1ps
module brg_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  brg_pkg::brg_head_t head_i,
  output logic               pop_o,
  brg_rsp_if.source          rsp_o
);
  import brg_pkg::*;

  localparam int unsigned StepW = $clog2(DataW);
  localparam logic [StepW-1:0] LastStep = StepW'(DataW - 1);

  brg_state_e        state_q, state_d;
  logic [DataW-1:0]  quo_q;
  logic [DataW-1:0]  rem_q;
  logic [DataW-1:0]  div_q;
  logic              zero_q;
  logic [StepW-1:0]  step_q;
  logic              out_valid_q;
  logic [DataW-1:0]  out_value_q;
  logic              out_zero_q;
  logic              out_free;
  logic              load_job;
  logic              do_step;
  logic              load_out;
  logic [DataW:0]    rem_shift;
  logic [DataW:0]    rem_diff;

  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!head_i.empty) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_q == LastStep) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    load_job = 1'b0;
    do_step  = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: load_job = !head_i.empty;
      ST_RUN:  do_step  = 1'b1;
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  assign pop_o     = load_job;
  assign rem_shift = {rem_q, quo_q[DataW-1]};
  assign rem_diff  = rem_shift - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (load_job) begin
        step_q <= '0;
      end else if (do_step) begin
        step_q <= step_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_job) begin
      quo_q  <= head_i.job.raw;
      rem_q  <= '0;
      div_q  <= head_i.job.limit;
      zero_q <= (head_i.job.limit == '0);
    end else if (do_step) begin
      quo_q <= {quo_q[DataW-2:0], 1'b0};
      if (!rem_diff[DataW]) begin
        rem_q <= rem_diff[DataW-1:0];
      end else begin
        rem_q <= rem_shift[DataW-1:0];
      end
    end
    if (load_out) begin
      out_value_q <= zero_q ? '0 : rem_q;
      out_zero_q  <= zero_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.value      = out_value_q;
  assign rsp_o.limit_zero = out_zero_q;

endmodule

>>> rtl/core/bounded_random_generator.sv
// Top level of the bounded random generator: front end, job queue and divider back end.
// A job passes through the queue, then a load state in the back end, the 32 steps of the
// radix-2 divider and a DONE state that fills the response register once it is free.
// The back end works on one job at a time and loads the next only after leaving DONE.
// The front end takes requests while the queue has room, so requests overlap division.
// Reset sets all four generator components to 12345 and empties the queue and output.
`timescale 1ns / 1ps
module bounded_random_generator #(
  parameter int unsigned QueueDepth = brg_pkg::QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  brg_req_if.sink   req_i,
  brg_rsp_if.source rsp_o
);
  import brg_pkg::*;

  brg_push_t push;
  brg_head_t head;
  logic      full;
  logic      pop;

  brg_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .full_i (full),
    .push_o (push)
  );

  brg_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  brg_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .rsp_o  (rsp_o)
  );

endmodule

>>> rtl/core/brg_checker.sv
// Port-level checker for the bounded random generator and its bind statement.
`timescale 1ns / 1ps
module brg_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic [brg_pkg::DataW-1:0] rsp_value_i,
  input logic                      rsp_limit_zero_i
);
  import brg_pkg::*;

  // A zero limit always yields a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_limit_zero_i) |-> (rsp_value_i == '0))
    else $error("Zero-limit response carries a nonzero value.");

  // A stalled response holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_value_i) && $stable(rsp_limit_zero_i)))
    else $error("Stalled response changed or dropped.");

  // No response is offered while reset is applied.
  assert property (@(posedge clk_i) !rst_ni |-> !rsp_valid_i)
    else $error("Response valid during reset.");

  // A response that appears right after reset cannot come from any request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !rsp_valid_i)
    else $error("Response valid right after reset.");

  // The request side must be able to accept right after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(!rst_ni) && req_valid_i) |-> req_ready_i)
    else $error("Request stalled with an empty queue.");

endmodule

bind bounded_random_generator brg_checker u_brg_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_value_i      (rsp_o.value),
  .rsp_limit_zero_i (rsp_o.limit_zero)
);
